>>> rtl/arc4_stream_cipher_core_defines.svh
// Assertion macros shared by the ARC4 cipher core.
`ifndef ARC4_STREAM_CIPHER_CORE_DEFINES_SVH
`define ARC4_STREAM_CIPHER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define ARC4_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("arc4 core: implication check failed");

// Next-cycle implication, checked outside reset
`define ARC4_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("arc4 core: next-cycle check failed");

`endif

>>> rtl/arc4_pkg.sv
// Package: types and constants of the ARC4 cipher core.
`default_nettype none
package arc4_pkg;

    localparam int PERM_DEPTH    = 256;
    localparam int PERM_AW       = 8;
    localparam int KEY_MAX_DEF   = 256;

    // Operation codes of an input transaction
    localparam logic OP_KEY  = 1'b0;
    localparam logic OP_DATA = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_D_RDB,
        ST_D_SWP,
        ST_D_KS,
        ST_K_RD,
        ST_K_ADD,
        ST_K_SWP,
        ST_K_WR
    } t_state;

endpackage
`default_nettype wire

>>> rtl/arc4_stream_cipher_core.sv
// ARC4 stream cipher core: key loading, key schedule and keystream generator.
//
// Input channel (i_in_valid / o_in_ready) carries one transaction per byte.
// i_operation = key selects key loading: the byte is stored (bytes past
// KEY_MAX_BYTES are dropped). A key byte with i_last set also runs the key
// schedule: 256 swap steps, each through ST_K_RD, ST_K_ADD, ST_K_SWP and
// ST_K_WR, before the next transaction is taken. Key transactions give no result.
// i_operation = data runs one generator step and returns the byte XOR the
// keystream byte with the last flag copied, on o_out_valid / i_out_ready.
// A data byte passes through ST_D_RDB and ST_D_SWP into ST_D_KS, which loads
// the output register, and the next transaction is taken back in ST_IDLE;
// the single read port of the permutation memory sets this sequence (three
// dependent reads per byte).
// The input side stays not ready while a byte is being worked on.
// A stalled receiver holds the output register; a following data byte then
// waits in its last step until the register frees up. Key bytes still load.
// Reset (i_rst_n low, synchronous) restores the identity permutation at once
// through per-entry valid bits, clears both indices and the key count, and
// empties the output register. No clearing pass is needed.
`default_nettype none
`include "arc4_stream_cipher_core_defines.svh"

module arc4_stream_cipher_core #(
    parameter int KEY_MAX_BYTES = arc4_pkg::KEY_MAX_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic       i_operation,
    input  wire logic [7:0] i_byte_in,
    input  wire logic       i_last,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [7:0]      o_out_byte,
    output logic            o_out_last
);

    localparam int KW = (KEY_MAX_BYTES > 1) ? $clog2(KEY_MAX_BYTES) : 1;
    localparam int CW = $clog2(KEY_MAX_BYTES + 1);
    localparam int AW = arc4_pkg::PERM_AW;

    arc4_pkg::t_state r_state, n_state;

    // Permutation memory with per-entry valid bits (invalid reads as identity)
    logic [AW-1:0] perm_mem [0:arc4_pkg::PERM_DEPTH-1];
    logic [arc4_pkg::PERM_DEPTH-1:0] r_valid;
    logic [AW-1:0] r_p_rdata, r_p_raddr;
    logic          r_p_rvld;
    logic          p_rd_en, p_wr_en;
    logic [AW-1:0] p_rd_addr, p_wr_addr, p_wr_data;
    logic [AW-1:0] pv;

    // Key memory
    logic [7:0]    key_mem [0:KEY_MAX_BYTES-1];
    logic [7:0]    r_k_rdata;
    logic          k_rd_en, k_wr_en;

    // Generator and schedule registers
    logic [AW-1:0] r_a, r_b, r_si, r_sj, r_acc, r_n;
    logic [KW-1:0] r_kp;
    logic [CW-1:0] r_key_count;
    logic [7:0]    r_byte;
    logic          r_last;
    logic          r_out_valid;
    logic [7:0]    r_out_byte;
    logic          r_out_last;

    logic          in_acc, out_free, out_load, sched_start;
    logic [AW-1:0] acc_new, sel, ks;

    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign sched_start = in_acc && (i_operation == arc4_pkg::OP_KEY) && i_last;
    assign k_wr_en     = in_acc && (i_operation == arc4_pkg::OP_KEY)
                         && (r_key_count < CW'(KEY_MAX_BYTES));
    assign pv          = r_p_rvld ? r_p_rdata : r_p_raddr;
    assign acc_new     = r_acc + pv + r_k_rdata;
    assign sel         = r_si + r_sj;
    // Bypass the swap writes that the keystream read did not see
    assign ks          = (sel == r_b) ? r_si : ((sel == r_a) ? r_sj : pv);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            arc4_pkg::ST_IDLE: begin
                if (in_acc && (i_operation == arc4_pkg::OP_DATA)) begin
                    n_state = arc4_pkg::ST_D_RDB;
                end else if (sched_start) begin
                    n_state = arc4_pkg::ST_K_RD;
                end
            end
            arc4_pkg::ST_D_RDB: n_state = arc4_pkg::ST_D_SWP;
            arc4_pkg::ST_D_SWP: n_state = arc4_pkg::ST_D_KS;
            arc4_pkg::ST_D_KS:  n_state = out_free ? arc4_pkg::ST_IDLE : arc4_pkg::ST_D_KS;
            arc4_pkg::ST_K_RD:  n_state = arc4_pkg::ST_K_ADD;
            arc4_pkg::ST_K_ADD: n_state = arc4_pkg::ST_K_SWP;
            arc4_pkg::ST_K_SWP: n_state = arc4_pkg::ST_K_WR;
            arc4_pkg::ST_K_WR: begin
                n_state = (r_n == AW'(arc4_pkg::PERM_DEPTH - 1)) ? arc4_pkg::ST_IDLE
                                                                 : arc4_pkg::ST_K_RD;
            end
            default: n_state = arc4_pkg::ST_IDLE;
        endcase
    end

    // Memory port control per state
    always_comb begin
        o_in_ready = 1'b0;
        p_rd_en    = 1'b0;
        p_rd_addr  = r_n;
        p_wr_en    = 1'b0;
        p_wr_addr  = r_n;
        p_wr_data  = pv;
        k_rd_en    = 1'b0;
        out_load   = 1'b0;
        unique case (r_state)
            arc4_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                p_rd_en    = in_acc && (i_operation == arc4_pkg::OP_DATA);
                p_rd_addr  = r_a + AW'(1);
            end
            arc4_pkg::ST_D_RDB: begin
                p_rd_en   = 1'b1;
                p_rd_addr = r_b + pv;
            end
            arc4_pkg::ST_D_SWP: begin
                p_rd_en   = 1'b1;
                p_rd_addr = r_si + pv;
                p_wr_en   = 1'b1;
                p_wr_addr = r_a;
                p_wr_data = pv;
            end
            arc4_pkg::ST_D_KS: begin
                p_wr_en   = 1'b1;
                p_wr_addr = r_b;
                p_wr_data = r_si;
                out_load  = out_free;
            end
            arc4_pkg::ST_K_RD: begin
                p_rd_en   = 1'b1;
                p_rd_addr = r_n;
                k_rd_en   = 1'b1;
            end
            arc4_pkg::ST_K_ADD: begin
                p_rd_en   = 1'b1;
                p_rd_addr = acc_new;
            end
            arc4_pkg::ST_K_SWP: begin
                p_wr_en   = 1'b1;
                p_wr_addr = r_n;
                p_wr_data = pv;
            end
            arc4_pkg::ST_K_WR: begin
                p_wr_en   = 1'b1;
                p_wr_addr = r_acc;
                p_wr_data = r_si;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= arc4_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Permutation memory array
    always_ff @(posedge i_clk) begin
        if (p_wr_en) begin
            perm_mem[p_wr_addr] <= p_wr_data;
        end
        if (p_rd_en) begin
            r_p_rdata <= perm_mem[p_rd_addr];
            r_p_raddr <= p_rd_addr;
        end
    end

    // Valid bits: clear for identity, set on write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_p_rvld <= 1'b0;
        end else begin
            if (p_rd_en) begin
                r_p_rvld <= r_valid[p_rd_addr];
            end
            if (sched_start) begin
                r_valid <= '0;
            end else if (p_wr_en) begin
                r_valid[p_wr_addr] <= 1'b1;
            end
        end
    end

    // Key memory array
    always_ff @(posedge i_clk) begin
        if (k_wr_en) begin
            key_mem[r_key_count[KW-1:0]] <= i_byte_in;
        end
        if (k_rd_en) begin
            r_k_rdata <= key_mem[r_kp];
        end
    end

    // Control registers: indices, key count, schedule counters, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a         <= '0;
            r_b         <= '0;
            r_key_count <= '0;
            r_n         <= '0;
            r_acc       <= '0;
            r_kp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc && (i_operation == arc4_pkg::OP_DATA)) begin
                r_a <= r_a + AW'(1);
            end
            if (k_wr_en) begin
                r_key_count <= r_key_count + CW'(1);
            end
            if (sched_start) begin
                r_a   <= '0;
                r_b   <= '0;
                r_n   <= '0;
                r_acc <= '0;
                r_kp  <= '0;
            end
            if (r_state == arc4_pkg::ST_D_RDB) begin
                r_b <= r_b + pv;
            end
            if (r_state == arc4_pkg::ST_K_ADD) begin
                r_acc <= acc_new;
            end
            // Advance the schedule step and wrap the key pointer at the key length
            if (r_state == arc4_pkg::ST_K_WR) begin
                r_n <= r_n + AW'(1);
                if (CW'(r_kp) == r_key_count - CW'(1)) begin
                    r_kp <= '0;
                end else begin
                    r_kp <= r_kp + KW'(1);
                end
                if (r_n == AW'(arc4_pkg::PERM_DEPTH - 1)) begin
                    r_key_count <= '0;
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_byte <= i_byte_in;
            r_last <= i_last;
        end
        if ((r_state == arc4_pkg::ST_D_RDB) || (r_state == arc4_pkg::ST_K_ADD)) begin
            r_si <= pv;
        end
        if (r_state == arc4_pkg::ST_D_SWP) begin
            r_sj <= pv;
        end
        if (out_load) begin
            r_out_byte <= r_byte ^ ks;
            r_out_last <= r_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_out_last  = r_out_last;

    // Schedule start clears the generator and falls back to identity
    `ARC4_ASSERT_NEXT(a_sched_start, i_clk, i_rst_n, sched_start,
        (r_state == arc4_pkg::ST_K_RD) && (r_valid == '0) && (r_a == '0) && (r_b == '0))
    // Last schedule step ends the key
    `ARC4_ASSERT_NEXT(a_sched_end, i_clk, i_rst_n,
        (r_state == arc4_pkg::ST_K_WR) && (r_n == AW'(arc4_pkg::PERM_DEPTH - 1)),
        (r_state == arc4_pkg::ST_IDLE) && (r_key_count == '0))
    // Key pointer stays inside the loaded key during the schedule
    `ARC4_ASSERT_IMPL(a_kp_range, i_clk, i_rst_n, (r_state == arc4_pkg::ST_K_RD),
        (CW'(r_kp) < r_key_count))
    // An accepted data byte enters the generator step
    `ARC4_ASSERT_NEXT(a_data_step, i_clk, i_rst_n,
        in_acc && (i_operation == arc4_pkg::OP_DATA), (r_state == arc4_pkg::ST_D_RDB))

endmodule
`default_nettype wire

>>> tb/arc4_stream_cipher_checker.sv
// Checker for the ARC4 cipher core: tracks the cipher state and scores every output.
module arc4_stream_cipher_checker (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic       i_in_ready,
    input  wire logic       i_operation,
    input  wire logic [7:0] i_byte_in,
    input  wire logic       i_last,
    input  wire logic       i_out_valid,
    input  wire logic       i_out_ready,
    input  wire logic [7:0] i_out_byte,
    input  wire logic       i_out_last,
    output int              o_fail_count,
    output int              o_pending,
    output int              o_data_bytes,
    output int              o_key_bytes,
    output int              o_schedules
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_cipher_out;

    // Shadow copy of the cipher state
    logic [7:0]  perm [arc4_pkg::PERM_DEPTH];
    logic [7:0]  key_mem [arc4_pkg::PERM_DEPTH];
    logic [8:0]  key_len;
    logic [7:0]  idx_a;
    logic [7:0]  idx_b;

    // Cipher bytes still owed by the core, oldest first
    t_cipher_out cipher_q [$];

    task automatic set_identity();
        for (int n = 0; n < arc4_pkg::PERM_DEPTH; n++) begin
            perm[n] = n[7:0];
        end
        idx_a = 8'd0;
        idx_b = 8'd0;
    endtask

    // Key schedule over the bytes loaded for the current key, repeated cyclically
    task automatic run_key_schedule();
        logic [7:0] acc;
        logic [7:0] tmp;
        int         len;
        len = (key_len == 9'd0) ? 1 : int'(key_len);
        set_identity();
        acc = 8'd0;
        for (int n = 0; n < arc4_pkg::PERM_DEPTH; n++) begin
            acc = acc + perm[n] + key_mem[n % len];
            tmp = perm[n];
            perm[n] = perm[acc];
            perm[acc] = tmp;
        end
    endtask

    // Advance the generator one step and return the enciphered byte
    task automatic cipher_step(input logic [7:0] plain, output logic [7:0] cipher);
        logic [7:0] tmp;
        logic [7:0] sel;
        idx_a = idx_a + 8'd1;
        idx_b = idx_b + perm[idx_a];
        tmp = perm[idx_a];
        perm[idx_a] = perm[idx_b];
        perm[idx_b] = tmp;
        sel = perm[idx_a] + perm[idx_b];
        cipher = plain ^ perm[sel];
    endtask

    always @(posedge i_clk) begin
        t_cipher_out got;
        t_cipher_out want;
        logic [7:0]  cipher;
        if (!i_rst_n) begin
            set_identity();
            key_len = 9'd0;
            cipher_q.delete();
        end else begin
            // Score the output transaction before queuing anything new
            if (i_out_valid && i_out_ready) begin
                got = t_cipher_out'{i_out_byte, i_out_last};
                if (cipher_q.size() == 0) begin
                    $error("unexpected output transaction: out_byte %02h out_last %0b",
                           got.data, got.last);
                    o_fail_count++;
                end else begin
                    want = cipher_q.pop_front();
                    if (got.data !== want.data) begin
                        $error("out_byte: expected %02h, actual %02h", want.data, got.data);
                        o_fail_count++;
                    end
                    if (got.last !== want.last) begin
                        $error("out_last: expected %0b, actual %0b", want.last, got.last);
                        o_fail_count++;
                    end
                end
            end

            // Update the shadow state on each input transaction
            if (i_in_valid && i_in_ready) begin
                if (i_operation == arc4_pkg::OP_DATA) begin
                    cipher_step(i_byte_in, cipher);
                    cipher_q.push_back(t_cipher_out'{cipher, i_last});
                    o_data_bytes++;
                end else begin
                    // Drop key bytes past the maximum key length
                    if (key_len < 9'(arc4_pkg::KEY_MAX_DEF)) begin
                        key_mem[key_len[7:0]] = i_byte_in;
                        key_len = key_len + 9'd1;
                    end
                    o_key_bytes++;
                    if (i_last) begin
                        run_key_schedule();
                        key_len = 9'd0;
                        o_schedules++;
                    end
                end
            end
        end
        o_pending = cipher_q.size();
    end

endmodule

>>> tb/tb_arc4_stream_cipher_core.sv
// Testbench top for the ARC4 cipher core: stimulus, handshake pacing and verdict.
module tb_arc4_stream_cipher_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT  = 20000;
    localparam int DRAIN_CYCLES    = 1100;  // one full key schedule plus margin
    localparam int HOLD_CYCLES     = 300;
    localparam int ITEMS_PER_PHASE = 385;
    localparam int NUM_PHASES      = 4;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic       o_in_ready;
    logic       i_operation = arc4_pkg::OP_KEY;
    logic [7:0] i_byte_in   = 8'h00;
    logic       i_last      = 1'b0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    logic [7:0] o_out_byte;
    logic       o_out_last;

    int fail_count;
    int pending;
    int data_bytes;
    int key_bytes;
    int schedules;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_requests  = 0;
    int hold_seen      = 0;
    int hold_left      = 0;
    int quiet_cycles   = 0;

    arc4_stream_cipher_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_operation (i_operation),
        .i_byte_in   (i_byte_in),
        .i_last      (i_last),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_byte  (o_out_byte),
        .o_out_last  (o_out_last)
    );

    arc4_stream_cipher_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_operation  (i_operation),
        .i_byte_in    (i_byte_in),
        .i_last       (i_last),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_byte   (o_out_byte),
        .i_out_last   (o_out_last),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_data_bytes (data_bytes),
        .o_key_bytes  (key_bytes),
        .o_schedules  (schedules)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver: random stalls, plus a long hold-off on each request
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_ready = 1'b0;
            hold_left--;
        end else if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES - 1;
            i_out_ready = 1'b0;
        end else begin
            i_out_ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: end the run when no transaction moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("arc4_stream_cipher_core: mismatch");
            $finish;
        end
    end

    // Offer one transaction and hold it until accepted; returns at a falling edge
    task automatic send_item(input logic op, input logic [7:0] value, input logic lst);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  = 1'b1;
        i_operation = op;
        i_byte_in   = value;
        i_last      = lst;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        @(negedge i_clk);
    endtask

    task automatic send_key(input int len);
        for (int n = 0; n < len; n++) begin
            send_item(arc4_pkg::OP_KEY, 8'($urandom), n == len - 1);
        end
    endtask

    task automatic send_message(input int len);
        for (int n = 0; n < len; n++) begin
            send_item(arc4_pkg::OP_DATA, 8'($urandom), n == len - 1);
        end
    endtask

    task automatic wait_drained();
        i_in_valid = 1'b0;
        while (pending != 0) begin
            @(negedge i_clk);
        end
    endtask

    initial begin
        int         sent;
        int         kind;
        int         klen;
        int         mlen;
        int         n;
        bit         first;
        logic       op;
        logic       lst;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Data before any key runs on the identity permutation
        send_item(arc4_pkg::OP_DATA, 8'h00, 1'b0);
        send_item(arc4_pkg::OP_DATA, 8'hFF, 1'b0);
        send_item(arc4_pkg::OP_DATA, 8'hA5, 1'b1);
        // Shortest key
        send_item(arc4_pkg::OP_KEY, 8'h00, 1'b1);
        send_item(arc4_pkg::OP_DATA, 8'hFF, 1'b0);
        send_item(arc4_pkg::OP_DATA, 8'h00, 1'b1);
        // Data in the middle of an unfinished key, then finish the key
        send_item(arc4_pkg::OP_KEY, 8'hFF, 1'b0);
        send_item(arc4_pkg::OP_KEY, 8'h80, 1'b0);
        send_item(arc4_pkg::OP_DATA, 8'h5A, 1'b1);
        send_item(arc4_pkg::OP_KEY, 8'h01, 1'b1);
        send_item(arc4_pkg::OP_DATA, 8'h55, 1'b0);
        send_item(arc4_pkg::OP_DATA, 8'hAA, 1'b1);
        // Textbook vector: key "Key", plaintext "Plain"
        send_item(arc4_pkg::OP_KEY, 8'h4B, 1'b0);
        send_item(arc4_pkg::OP_KEY, 8'h65, 1'b0);
        send_item(arc4_pkg::OP_KEY, 8'h79, 1'b1);
        send_item(arc4_pkg::OP_DATA, 8'h50, 1'b0);
        send_item(arc4_pkg::OP_DATA, 8'h6C, 1'b0);
        send_item(arc4_pkg::OP_DATA, 8'h61, 1'b0);
        send_item(arc4_pkg::OP_DATA, 8'h69, 1'b0);
        send_item(arc4_pkg::OP_DATA, 8'h6E, 1'b1);

        // Random part, one handshake setting per phase
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            // Pause the sender until the core has returned everything
            wait_drained();
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
                default: begin send_idle_pct = 20; recv_stall_pct = 20; end
            endcase
            sent  = 0;
            first = 1'b1;
            while (sent < ITEMS_PER_PHASE) begin
                kind = $urandom_range(99);
                if (first && phase == 0) begin
                    klen = arc4_pkg::KEY_MAX_DEF + $urandom_range(1, 24);  // over-length key
                end else if (first && phase == 2) begin
                    klen = arc4_pkg::KEY_MAX_DEF;
                end else if (kind < 5) begin
                    klen = $urandom_range(17, 64);
                end else begin
                    klen = $urandom_range(1, 16);
                end
                if (kind >= 85 && !first) begin
                    // Loose mix: keys left open, data mid-key, random flags
                    n = $urandom_range(1, 12);
                    repeat (n) begin
                        op  = 1'($urandom_range(1));
                        lst = (op == arc4_pkg::OP_KEY) ? ($urandom_range(3) == 0)
                                                       : 1'($urandom_range(1));
                        send_item(op, 8'($urandom), lst);
                    end
                    sent += n;
                end else begin
                    send_key(klen);
                    sent += klen;
                    mlen = first ? $urandom_range(8, 24) : $urandom_range(1, 40);
                    // Hold the receiver off so the core backs up into its input
                    if (first) hold_requests++;
                    send_message(mlen);
                    sent += mlen;
                end
                first = 1'b0;
            end
        end

        // Wait for the last results and let any key schedule run out
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("run covered %0d data bytes and %0d key bytes over %0d key schedules,",
                 data_bytes, key_bytes, schedules);
        $display("with idle-free, sender-idle, receiver-stall and mixed phases plus hold-offs");
        if (fail_count == 0 && pending == 0) begin
            $display("arc4_stream_cipher_core: match");
        end else begin
            $display("arc4_stream_cipher_core: mismatch");
        end
        $finish;
    end

endmodule
